### design/q2e_pkg.sv
// shared types, widths and constants for the quaternion to euler angle block
// no dependencies
`default_nettype none

package q2e_pkg;

  // default configuration
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 30;

  // datapath widths
  localparam int QW   = 16;  // quaternion component
  localparam int SW   = 34;  // product sums, 2^28 = 1.0
  localparam int PW   = 29;  // in-range pitch sine
  localparam int SQW  = 56;  // square of the pitch sine
  localparam int RADW = 58;  // isqrt radicand, padded to an even width
  localparam int RTW  = RADW / 2;  // isqrt root
  localparam int REMW = 32;  // isqrt remainder
  localparam int CW   = 38;  // cordic x and y
  localparam int ZW   = 34;  // cordic angle accumulator, 2^31 = pi

  localparam logic signed [SW-1:0] ONE_Q28   = SW'(64'sd268435456);
  localparam logic signed [ZW-1:0] PI_ACC    = ZW'(64'sd2147483648);
  localparam logic signed [ZW-1:0] HALF_PI   = ZW'(64'sd1073741824);
  localparam logic [RADW-1:0]      RAD_ONE   = RADW'(1) << SQW;

  // atan(2^-i) in accumulator units
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    ZW'(64'sd536870912), ZW'(64'sd316933406), ZW'(64'sd167458907),
    ZW'(64'sd85004756),  ZW'(64'sd42667331),  ZW'(64'sd21354465),
    ZW'(64'sd10679838),  ZW'(64'sd5340245),   ZW'(64'sd2670163),
    ZW'(64'sd1335087),   ZW'(64'sd667544),    ZW'(64'sd333772),
    ZW'(64'sd166886),    ZW'(64'sd83443),     ZW'(64'sd41722),
    ZW'(64'sd20861),     ZW'(64'sd10430),     ZW'(64'sd5215),
    ZW'(64'sd2608),      ZW'(64'sd1304),      ZW'(64'sd652),
    ZW'(64'sd326),       ZW'(64'sd163),       ZW'(64'sd81),
    ZW'(64'sd41),        ZW'(64'sd20),        ZW'(64'sd10),
    ZW'(64'sd5),         ZW'(64'sd3),         ZW'(64'sd1)
  };

  // flags that travel with a sample to the end
  typedef struct packed {
    logic sample_valid;
    logic clamp_pos;
    logic clamp_neg;
  } q2e_tag_t;

  // product sums carried past the square root
  typedef struct packed {
    q2e_tag_t               tag;
    logic signed [PW-1:0]   sp;
    logic signed [SW-1:0]   sr;
    logic signed [SW-1:0]   cr;
    logic signed [SW-1:0]   sy;
    logic signed [SW-1:0]   cy;
  } q2e_side_t;

endpackage

`default_nettype wire

### design/q2e_quat_if.sv
// input channel: one quaternion sample per transaction
// no dependencies
`default_nettype none

interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               sample_valid;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, sample_valid,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, sample_valid,
                  output ready);
endinterface

`default_nettype wire

### design/q2e_euler_if.sv
// output channel: one set of binary angles per transaction
// no dependencies
`default_nettype none

interface q2e_euler_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  logic                          angles_valid;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, angles_valid,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, angles_valid,
                  output ready);
endinterface

`default_nettype wire

### design/q2e_front.sv
// front end: products, sums, pitch clamp and the isqrt radicand
// depends on q2e_pkg
`default_nettype none

module q2e_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [15:0]        quat_w,
  input  wire logic signed [15:0]        quat_x,
  input  wire logic signed [15:0]        quat_y,
  input  wire logic signed [15:0]        quat_z,
  input  wire logic                      sample_valid,
  output logic                           out_valid,
  output logic [q2e_pkg::RADW-1:0]       radicand,
  output q2e_pkg::q2e_side_t             side
);
  import q2e_pkg::*;

  // stage 1: input registers
  logic                   v1;
  logic signed [QW-1:0]   w1, x1, y1, z1;
  logic                   sv1;
  // stage 2: products
  logic                   v2;
  logic                   sv2;
  logic signed [31:0]     wx, yz, xx, yy, wy, zx, wz, xy, zz;
  // stage 3: sums
  logic                   v3;
  q2e_side_t              s3;
  logic signed [SW-1:0]   sp3;
  // stage 4: square
  logic                   v4;
  q2e_side_t              s4;
  logic [SQW-1:0]         sq4;

  logic signed [SW-1:0]   sp_full;
  logic signed [SW-1:0]   sr_c, cr_c, sy_c, cy_c;
  logic signed [2*PW-1:0] sq_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (en) begin
      w1  <= quat_w;
      x1  <= quat_x;
      y1  <= quat_y;
      z1  <= quat_z;
      sv1 <= sample_valid;
    end
  end

  // nine signed products in parallel
  always_ff @(posedge clk) begin
    if (en) begin
      sv2 <= sv1;
      wx  <= 32'(w1 * x1);
      yz  <= 32'(y1 * z1);
      xx  <= 32'(x1 * x1);
      yy  <= 32'(y1 * y1);
      wy  <= 32'(w1 * y1);
      zx  <= 32'(z1 * x1);
      wz  <= 32'(w1 * z1);
      xy  <= 32'(x1 * y1);
      zz  <= 32'(z1 * z1);
    end
  end

  // product sums, scaled so that 2^28 is 1.0
  always_comb begin
    sr_c    = SW'(wx + 33'sd0 + yz) <<< 1;
    cr_c    = ONE_Q28 - (SW'(xx + 33'sd0 + yy) <<< 1);
    sp_full = SW'(wy + 33'sd0 - zx) <<< 1;
    sy_c    = SW'(wz + 33'sd0 + xy) <<< 1;
    cy_c    = ONE_Q28 - (SW'(yy + 33'sd0 + zz) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.tag.sample_valid <= sv2;
      s3.tag.clamp_pos    <= (sp_full >= ONE_Q28);
      s3.tag.clamp_neg    <= (sp_full <= -ONE_Q28);
      s3.sp               <= PW'(sp_full);
      s3.sr               <= sr_c;
      s3.cr               <= cr_c;
      s3.sy               <= sy_c;
      s3.cy               <= cy_c;
      sp3                 <= sp_full;
    end
  end

  // square of the in-range pitch sine; zero when clamped
  always_comb begin
    if (s3.tag.clamp_pos || s3.tag.clamp_neg) begin
      sq_full = '0;
    end else begin
      sq_full = PW'(sp3) * PW'(sp3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4  <= s3;
      sq4 <= SQW'(sq_full);
    end
  end

  // radicand 1.0^2 - s^2
  always_ff @(posedge clk) begin
    if (en) begin
      side     <= s4;
      radicand <= RAD_ONE - RADW'(sq4);
    end
  end

endmodule

`default_nettype wire

### design/q2e_isqrt.sv
// pipelined integer square root, one root bit per stage, truncating
// depends on q2e_pkg
`default_nettype none

module q2e_isqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [q2e_pkg::RADW-1:0] radicand,
  input  wire q2e_pkg::q2e_side_t      side_in,
  output logic                         out_valid,
  output logic [q2e_pkg::RTW-1:0]      root,
  output q2e_pkg::q2e_side_t           side_out
);
  import q2e_pkg::*;

  logic              v   [RTW+1];
  logic [RADW-1:0]   rad [RTW+1];
  logic [REMW-1:0]   rem [RTW+1];
  logic [RTW-1:0]    q   [RTW+1];
  q2e_side_t         sd  [RTW+1];

  assign v[0]   = in_valid;
  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [REMW-1:0] rem_n;
    logic [REMW-1:0] trial;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_n = {rem[k][REMW-3:0], rad[k][RADW-1 -: 2]};
      trial = REMW'({q[k], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k] << 2;
        sd[k+1]  <= sd[k];
        if (rem_n >= trial) begin
          rem[k+1] <= rem_n - trial;
          q[k+1]   <= {q[k][RTW-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem_n;
          q[k+1]   <= {q[k][RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[RTW];
  assign root      = q[RTW];
  assign side_out  = sd[RTW];

endmodule

`default_nettype wire

### design/q2e_cordic.sv
// pipelined vectoring cordic for atan2, one micro-rotation per stage
// depends on q2e_pkg
`default_nettype none

module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [q2e_pkg::CW-1:0] y_in,
  input  wire logic signed [q2e_pkg::CW-1:0] x_in,
  input  wire q2e_pkg::q2e_tag_t             tag_in,
  output logic                               out_valid,
  output logic signed [q2e_pkg::ZW-1:0]      angle,
  output q2e_pkg::q2e_tag_t                  tag_out
);
  import q2e_pkg::*;

  logic                 v   [STAGES+1];
  logic signed [CW-1:0] xr  [STAGES+1];
  logic signed [CW-1:0] yr  [STAGES+1];
  logic signed [ZW-1:0] zr  [STAGES+1];
  logic                 zer [STAGES+1];
  q2e_tag_t             tg  [STAGES+1];

  // fold the left half plane and flag the zero vector
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tg[0]  <= tag_in;
      zer[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xr[0] <= -x_in;
        yr[0] <= -y_in;
        zr[0] <= (y_in >= 0) ? PI_ACC : -PI_ACC;
      end else begin
        xr[0] <= x_in;
        yr[0] <= y_in;
        zr[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;

    always_comb begin
      xs = xr[i] >>> i;
      ys = yr[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        tg[i+1]  <= tg[i];
        zer[i+1] <= zer[i];
        if (yr[i] >= 0) begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + ATAN_TAB[i];
        end else begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign out_valid = v[STAGES];
  assign angle     = zer[STAGES] ? '0 : zr[STAGES];
  assign tag_out   = tg[STAGES];

endmodule

`default_nettype wire

### design/quaternion_to_euler_angles.sv
// quaternion (zyx order) to robot roll, pitch and yaw for a +90 degree z mount
// top level; depends on q2e_pkg, q2e_quat_if, q2e_euler_if, q2e_front,
// q2e_isqrt and q2e_cordic
//
// usage:
//   quat carries one Q1.14 quaternion and a sample valid flag per transaction;
//   euler returns one set of binary angles (2^(ANGLE_WIDTH-1) = pi) per
//   transaction, in input order. a sample with sample_valid low gives zero
//   angles and angles_valid low.
//   pipeline: 5 front stages + 29 square root stages + (CORDIC_STAGES + 1)
//   cordic stages + 1 output register.
//   throughput: one transaction per cycle while the output buffer has room;
//   the 29-stage square root for the pitch cosine sets the depth.
//   the output side is a two-entry buffer. the whole pipeline advances while
//   the buffer has room, so quat.ready stays high while one result waits and
//   drops only when both entries are full; nothing is lost or repeated.
//   reset clears all valid bits and the buffer; the block is ready in the
//   first cycle after reset.
`default_nettype none

module quaternion_to_euler_angles #(
  parameter int ANGLE_WIDTH   = q2e_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  q2e_quat_if.sink     quat,
  q2e_euler_if.source  euler
);
  import q2e_pkg::*;

  localparam int SH = 32 - ANGLE_WIDTH;
  localparam logic signed [ZW-1:0] RND = (ZW'(1) << SH) >>> 1;
  localparam logic signed [ANGLE_WIDTH-1:0] AMAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
  localparam logic signed [ANGLE_WIDTH-1:0] AMIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll;
    logic signed [ANGLE_WIDTH-1:0] pitch;
    logic signed [ANGLE_WIDTH-1:0] yaw;
    logic                          ok;
  } res_t;

  logic               adv;
  logic               f_valid;
  logic [RADW-1:0]    f_rad;
  q2e_side_t          f_side;
  logic               r_valid;
  logic [RTW-1:0]     r_root;
  q2e_side_t          r_side;
  logic               c_valid;
  logic signed [ZW-1:0] z_pitch, z_roll, z_yaw;
  q2e_tag_t           c_tag;

  logic [1:0]         count;
  logic               wr_ptr, rd_ptr;
  res_t               buf_mem [2];
  res_t               res;
  logic               push, pop;

  logic signed [ZW-1:0]          pitch_acc;
  logic signed [ANGLE_WIDTH-1:0] raw_pitch, raw_roll, raw_yaw;

  // whole pipeline moves while the output buffer has room
  assign adv        = (count != 2'd2);
  assign quat.ready = adv;

  q2e_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (quat.valid),
    .quat_w       (quat.quat_w),
    .quat_x       (quat.quat_x),
    .quat_y       (quat.quat_y),
    .quat_z       (quat.quat_z),
    .sample_valid (quat.sample_valid),
    .out_valid    (f_valid),
    .radicand     (f_rad),
    .side         (f_side)
  );

  q2e_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .radicand  (f_rad),
    .side_in   (f_side),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  // sensor pitch: atan2(s, sqrt(1 - s^2))
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .y_in      (CW'(r_side.sp)),
    .x_in      (CW'({1'b0, r_root})),
    .tag_in    (r_side.tag),
    .out_valid (c_valid),
    .angle     (z_pitch),
    .tag_out   (c_tag)
  );

  // sensor roll
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .y_in      (CW'(r_side.sr)),
    .x_in      (CW'(r_side.cr)),
    .tag_in    (r_side.tag),
    .out_valid (),
    .angle     (z_roll),
    .tag_out   ()
  );

  // sensor yaw
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (r_valid),
    .y_in      (CW'(r_side.sy)),
    .x_in      (CW'(r_side.cy)),
    .tag_in    (r_side.tag),
    .out_valid (),
    .angle     (z_yaw),
    .tag_out   ()
  );

  // gimbal clamp, rounding to binary angles, the mount remap and zero angles for invalid samples
  always_comb begin
    if (c_tag.clamp_pos) begin
      pitch_acc = HALF_PI;
    end else if (c_tag.clamp_neg) begin
      pitch_acc = -HALF_PI;
    end else begin
      pitch_acc = z_pitch;
    end
    raw_pitch = ANGLE_WIDTH'((pitch_acc + RND) >>> SH);
    raw_roll  = ANGLE_WIDTH'((z_roll + RND) >>> SH);
    raw_yaw   = ANGLE_WIDTH'((z_yaw + RND) >>> SH);
    if (c_tag.sample_valid) begin
      res.roll  = raw_pitch;
      res.pitch = (raw_roll == AMIN) ? AMAX : -raw_roll;
      res.yaw   = raw_yaw;
      res.ok    = 1'b1;
    end else begin
      res.roll  = '0;
      res.pitch = '0;
      res.yaw   = '0;
      res.ok    = 1'b0;
    end
  end

  // two-entry output buffer
  assign push = c_valid && adv;
  assign pop  = euler.valid && euler.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= res;
    end
  end

  assign euler.valid        = (count != 2'd0);
  assign euler.roll_angle   = buf_mem[rd_ptr].roll;
  assign euler.pitch_angle  = buf_mem[rd_ptr].pitch;
  assign euler.yaw_angle    = buf_mem[rd_ptr].yaw;
  assign euler.angles_valid = buf_mem[rd_ptr].ok;

  // buffer occupancy never exceeds its two entries
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  // a push without a pop grows the buffer by one
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("output buffer count did not grow on push");

  // a pop without a push shrinks the buffer by one
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("output buffer count did not shrink on pop");

  // an invalid sample leaves zero angles
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (euler.valid && !euler.angles_valid) |->
      (euler.roll_angle == '0 && euler.pitch_angle == '0 && euler.yaw_angle == '0))
    else $error("invalid sample produced nonzero angles");

  // robot pitch never takes the most negative code after saturation
  a_pitch_sat: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (euler.pitch_angle != AMIN))
    else $error("robot pitch negation did not saturate");

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking bench for quaternion_to_euler_angles: directed and random quaternions
// depends on q2e_pkg, q2e_quat_if, q2e_euler_if and the block itself
`timescale 1ns / 1ps

module tb;

  localparam int AW         = q2e_pkg::ANGLE_WIDTH_DEF;
  localparam int WD_LIMIT   = 5000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               sv;
  } quat_sample_t;

  typedef struct {
    logic signed [AW-1:0] roll, pitch, yaw;
    logic                 av;
  } euler_set_t;

  logic clk;
  logic rst;

  q2e_quat_if                      quat_ch ();
  q2e_euler_if #(.ANGLE_WIDTH(AW)) euler_ch ();

  quaternion_to_euler_angles uut (
    .clk   (clk),
    .rst   (rst),
    .quat  (quat_ch),
    .euler (euler_ch)
  );

  quat_sample_t sample_q[$];
  euler_set_t   angle_q[$];
  int           idle_pct, stall_pct;
  logic         hold_armed, hold_used;
  int           hold_left;
  int           fails, sent, got, idle_cycles;

  // atan(2^-i), 2^31 = pi
  localparam longint ATAN_STEP [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  // vectoring cordic, result in 2^31 = pi units
  function automatic longint vector_angle(longint y, longint x);
    longint acc, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc += ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc -= ATAN_STEP[i];
      end
    end
    return acc;
  endfunction

  // truncating integer square root
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round accumulator to a binary angle, wrapping
  function automatic logic signed [AW-1:0] round_angle(longint acc);
    longint r;
    r = (acc + (64'sd1 <<< (31 - AW))) >>> (32 - AW);
    return r[AW-1:0];
  endfunction

  // expected robot angles for one sample
  function automatic euler_set_t mounted_angles(quat_sample_t s);
    euler_set_t e;
    longint w, x, y, z, sr, cr, sp, sy, cy, pacc, one;
    logic signed [AW-1:0] raw_roll;
    e = '{default: '0};
    if (!s.sv) return e;
    one = 64'sd1 <<< 28;
    w = s.w; x = s.x; y = s.y; z = s.z;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    // gimbal lock clamps pitch to a quarter turn
    if (sp >= one) pacc = 64'sd1 <<< 30;
    else if (sp <= -one) pacc = -(64'sd1 <<< 30);
    else pacc = vector_angle(sp, longint'(int_root((64'd1 << 56) - 64'(sp * sp))));
    e.roll   = round_angle(pacc);
    raw_roll = round_angle(vector_angle(sr, cr));
    // negation saturates at the most negative code
    e.pitch  = (raw_roll == {1'b1, {(AW-1){1'b0}}}) ? {1'b0, {(AW-1){1'b1}}} : -raw_roll;
    e.yaw    = round_angle(vector_angle(sy, cy));
    e.av     = 1'b1;
    return e;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: one sample per accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      quat_ch.valid <= 1'b0;
    end else if (!quat_ch.valid || quat_ch.ready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        quat_ch.quat_w       <= sample_q[0].w;
        quat_ch.quat_x       <= sample_q[0].x;
        quat_ch.quat_y       <= sample_q[0].y;
        quat_ch.quat_z       <= sample_q[0].z;
        quat_ch.sample_valid <= sample_q[0].sv;
        quat_ch.valid        <= 1'b1;
        void'(sample_q.pop_front());
      end else begin
        quat_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      euler_ch.ready <= 1'b0;
      hold_left      <= 0;
      hold_used      <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_used      <= 1'b1;
      hold_left      <= HOLD_LEN;
      euler_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      euler_ch.ready <= 1'b0;
    end else begin
      euler_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    quat_sample_t s;
    euler_set_t   e;
    if (!rst) begin
      if (quat_ch.valid && quat_ch.ready) begin
        s.w  = quat_ch.quat_w;
        s.x  = quat_ch.quat_x;
        s.y  = quat_ch.quat_y;
        s.z  = quat_ch.quat_z;
        s.sv = quat_ch.sample_valid;
        angle_q.push_back(mounted_angles(s));
        sent++;
      end
      if (euler_ch.valid && euler_ch.ready) begin
        got++;
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected angle transaction roll=%0d pitch=%0d yaw=%0d",
                   $realtime, euler_ch.roll_angle, euler_ch.pitch_angle, euler_ch.yaw_angle);
          fails++;
        end else begin
          e = angle_q.pop_front();
          if (euler_ch.roll_angle !== e.roll) begin
            $display("%0t: roll expected %0d got %0d", $realtime, e.roll, euler_ch.roll_angle);
            fails++;
          end
          if (euler_ch.pitch_angle !== e.pitch) begin
            $display("%0t: pitch expected %0d got %0d", $realtime, e.pitch,
                     euler_ch.pitch_angle);
            fails++;
          end
          if (euler_ch.yaw_angle !== e.yaw) begin
            $display("%0t: yaw expected %0d got %0d", $realtime, e.yaw, euler_ch.yaw_angle);
            fails++;
          end
          if (euler_ch.angles_valid !== e.av) begin
            $display("%0t: angles_valid expected %0b got %0b", $realtime, e.av,
                     euler_ch.angles_valid);
            fails++;
          end
        end
      end
    end
  end

  // watchdog: stalled with work pending
  always @(posedge clk) begin
    if (rst || (quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready) ||
        (sample_q.size() == 0 && angle_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, WD_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_sample(int w, int x, int y, int z, bit sv);
    quat_sample_t s;
    s.w = 16'(w); s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.sv = sv;
    sample_q.push_back(s);
  endtask

  function automatic int comp_in_range();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // random mix: in-range, near gimbal lock, raw bit patterns
  task automatic add_random(int n);
    int mode, a, b;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(99);
      if (mode < 65) begin
        add_sample(comp_in_range(), comp_in_range(), comp_in_range(), comp_in_range(),
                   $urandom_range(99) < 88);
      end else if (mode < 85) begin
        a = $urandom_range(16384, 10500);
        b = $urandom_range(16384, 10500);
        if ($urandom_range(1)) b = -b;
        add_sample(a, $urandom_range(600), b, $urandom_range(600), 1'b1);
      end else begin
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
      end
    end
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || angle_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    add_random(n);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    quat_ch.valid        = 1'b0;
    quat_ch.quat_w       = '0;
    quat_ch.quat_x       = '0;
    quat_ch.quat_y       = '0;
    quat_ch.quat_z       = '0;
    quat_ch.sample_valid = 1'b0;
    euler_ch.ready       = 1'b0;
    hold_armed = 1'b0;
    idle_pct = 0; stall_pct = 0;
    fails = 0; sent = 0; got = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, axes, extremes, invalid, gimbal lock, zero quaternion
    add_sample(16384, 0, 0, 0, 1'b1);
    add_sample(0, 16384, 0, 0, 1'b1);        // sensor roll of pi, negation saturates
    add_sample(0, -16384, 0, 0, 1'b1);
    add_sample(0, 0, 16384, 0, 1'b1);
    add_sample(0, 0, 0, 16384, 1'b1);        // yaw of pi wraps
    add_sample(-16384, 0, 0, 0, 1'b1);
    add_sample(11586, 0, 11586, 0, 1'b1);    // gimbal lock, positive
    add_sample(11586, 0, -11586, 0, 1'b1);   // gimbal lock, negative
    add_sample(11585, 0, 11585, 0, 1'b1);    // just below lock
    add_sample(11585, 0, 0, -11585, 1'b1);
    add_sample(0, 0, 0, 0, 1'b1);            // zero quaternion, all angles zero
    add_sample(16384, 16384, 16384, 16384, 0);
    add_sample(-32768, -32768, -32768, -32768, 1'b1);
    add_sample(32767, 32767, 32767, 32767, 1'b1);
    add_sample(-32768, 32767, -32768, 32767, 1'b1);
    add_sample(8192, 8192, 8192, 8192, 1'b1);
    add_sample(8192, -8192, 8192, -8192, 1'b1);
    add_sample(-16384, -16384, -16384, -16384, 1'b1);
    add_sample(16384, 16384, 16384, 16384, 1'b1);
    add_sample(0, 0, 0, 0, 1'b0);
    drain();

    run_phase(150, 0, 0);
    run_phase(150, 80, 0);
    run_phase(150, 0, 80);
    run_phase(150, 32, 32);

    // long receiver hold-off while the sender keeps offering
    idle_pct  = 0;
    stall_pct = 0;
    add_random(80);
    @(posedge clk);
    hold_armed <= 1'b1;
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d samples and %0d angle sets over five idling phases", sent, got);
    $display("including gimbal lock, wrap at pi, saturated negation and invalid samples");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
